FILE: hdl/te2f_pkg.sv
// Shared types and constants for the tensor element to binary32 converter.
// No dependencies.
`default_nettype none
package te2f_pkg;
	localparam logic [3:0] TYPE_F64  = 4'd0;
	localparam logic [3:0] TYPE_F32  = 4'd1;
	localparam logic [3:0] TYPE_F16  = 4'd2;
	localparam logic [3:0] TYPE_BF16 = 4'd3;
	localparam logic [3:0] TYPE_E5M2 = 4'd4;
	localparam logic [3:0] TYPE_E4M3 = 4'd5;
	localparam logic [3:0] TYPE_I64  = 4'd6;
	localparam logic [3:0] TYPE_I32  = 4'd7;
	localparam logic [3:0] TYPE_I16  = 4'd8;
	localparam logic [3:0] TYPE_I8   = 4'd9;
	localparam logic [3:0] TYPE_U8   = 4'd10;
	localparam logic [3:0] TYPE_BOOL = 4'd11;

	localparam logic [31:0] POS_INF = 32'h7F80_0000;
	localparam logic [31:0] QNAN    = 32'h7FC0_0000;

	// Classified item: either a finished word or a magnitude to round.
	typedef struct packed {
		logic        direct;   // bits holds the final word
		logic [31:0] bits;
		logic        sign;
		logic [63:0] mag;
		logic [11:0] exp2;     // signed scale: value = mag * 2^exp2
		logic        last;
	} work_t;
endpackage
`default_nettype wire

FILE: hdl/tensor_element_to_fp32.sv
// Tensor element to binary32 converter, top level.
// Channels: in (valid/stall, element_bits, last_in), out (valid/stall,
// single_bits, last_out), and a cfg write channel (valid/ready) for the
// element type register, reset to f32.
// One element per cycle sustained while the receiver does not stall. On the
// way from input transfer to output valid, the transfer edge writes the
// two-entry queue, the normalize stage then loads from the queue, and the
// rounded word from that stage is loaded into the output register.
// When the receiver stalls the back end holds; the queue fills and then
// in_stall rises. Reset empties the queue and pipeline; config writes are
// always ready and must happen while the block is idle.
// Depends on te2f_pkg, te2f_front, te2f_queue, te2f_back.
`default_nettype none
module tensor_element_to_fp32 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] element_bits,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      single_bits,
	output logic             last_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data
);
	import te2f_pkg::*;

	logic [3:0] type_q;
	work_t fw, qw;
	logic full, nonempty, pop;

	assign cfg_ready = 1'b1;
	assign in_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) type_q <= TYPE_F32;
		else if (cfg_valid) type_q <= cfg_data;
	end

	te2f_front u_front (.element_type(type_q), .element_bits, .last_in, .work(fw));

	te2f_queue u_queue (.clk, .arst_n, .push(in_valid && !full), .wdata(fw), .full,
		.pop, .nonempty, .rdata(qw));

	te2f_back u_back (.clk, .arst_n, .in_valid(nonempty), .in_work(qw), .in_pop(pop),
		.valid(out_valid), .stall(out_stall), .single_bits, .last_out);
endmodule
`default_nettype wire

FILE: hdl/te2f_front.sv
// Front end: classifies raw elements and unpacks them to sign, magnitude, scale.
// Depends on te2f_pkg.
`default_nettype none
module te2f_front (
	input  wire logic [3:0]  element_type,
	input  wire logic [63:0] element_bits,
	input  wire logic        last_in,
	output te2f_pkg::work_t  work
);
	import te2f_pkg::*;

	logic [15:0] h;
	logic [4:0]  hex;
	logic [10:0] dex;
	logic [63:0] neg;

	always_comb begin
		h   = (element_type == TYPE_E5M2) ? {element_bits[7:0], 8'h00} : element_bits[15:0];
		hex = h[14:10];
		dex = element_bits[62:52];
		neg = '0;
		work = '0;
		work.last = last_in;
		unique case (element_type)
			TYPE_F64: begin
				work.sign = element_bits[63];
				if (dex == 11'h7FF) begin
					work.direct = 1'b1;
					work.bits = (element_bits[51:0] == '0) ? ({element_bits[63], 31'd0} | POS_INF)
						: ({element_bits[63], 31'd0} | QNAN | {9'd0, element_bits[51:29]});
				end else if (dex == '0) begin
					work.mag  = {12'd0, element_bits[51:0]};
					work.exp2 = -12'sd1074;
				end else begin
					work.mag  = {11'd0, 1'b1, element_bits[51:0]};
					work.exp2 = 12'({1'b0, dex}) - 12'd1075;
				end
			end
			TYPE_F32: begin
				work.direct = 1'b1;
				work.bits = element_bits[31:0];
			end
			TYPE_F16, TYPE_E5M2: begin
				work.sign = h[15];
				if (hex == '0) begin
					work.mag  = {54'd0, h[9:0]};
					work.exp2 = -12'sd24;
				end else begin
					work.direct = 1'b1;
					work.bits = (hex == 5'h1F) ? ({h[15], 31'd0} | POS_INF | {9'd0, h[9:0], 13'd0})
						: {h[15], 8'({3'd0, hex} + 8'd112), h[9:0], 13'd0};
				end
			end
			TYPE_BF16: begin
				work.direct = 1'b1;
				work.bits = {element_bits[15:0], 16'd0};
			end
			TYPE_E4M3: begin
				work.sign = element_bits[7];
				if (element_bits[6:3] == '0) begin
					work.mag  = {61'd0, element_bits[2:0]};
					work.exp2 = -12'sd9;
				end else begin
					work.direct = 1'b1;
					work.bits = (element_bits[6:0] == 7'h7F) ? ({element_bits[7], 31'd0} | QNAN)
						: {element_bits[7], 8'({4'd0, element_bits[6:3]} + 8'd120),
							element_bits[2:0], 20'd0};
				end
			end
			TYPE_I64: begin
				neg = -element_bits;
				work.sign = element_bits[63];
				work.mag  = element_bits[63] ? neg : element_bits;
			end
			TYPE_I32: begin
				neg = 64'(-{32'd0, element_bits[31:0]});
				work.sign = element_bits[31];
				work.mag  = element_bits[31] ? {32'd0, neg[31:0]} : {32'd0, element_bits[31:0]};
			end
			TYPE_I16: begin
				neg = 64'(-{48'd0, element_bits[15:0]});
				work.sign = element_bits[15];
				work.mag  = element_bits[15] ? {48'd0, neg[15:0]} : {48'd0, element_bits[15:0]};
			end
			TYPE_I8: begin
				neg = 64'(-{56'd0, element_bits[7:0]});
				work.sign = element_bits[7];
				work.mag  = element_bits[7] ? {56'd0, neg[7:0]} : {56'd0, element_bits[7:0]};
			end
			TYPE_U8: work.mag = {56'd0, element_bits[7:0]};
			TYPE_BOOL: begin
				work.direct = 1'b1;
				work.bits = (element_bits[7:0] != '0) ? 32'h3F80_0000 : 32'd0;
			end
			default: work.direct = 1'b1;
		endcase
	end
endmodule
`default_nettype wire

FILE: hdl/te2f_queue.sv
// Two-entry queue between front and back ends.
// Depends on te2f_pkg.
`default_nettype none
module te2f_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  te2f_pkg::work_t      wdata,
	output logic                 full,
	input  wire logic            pop,
	output logic                 nonempty,
	output te2f_pkg::work_t      rdata
);
	import te2f_pkg::*;

	work_t mem_q [2];
	logic  wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end
endmodule
`default_nettype wire

FILE: hdl/te2f_back.sv
// Back end: normalize and round to binary32 in two stages, with output register.
// Depends on te2f_pkg.
`default_nettype none
module te2f_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  te2f_pkg::work_t  in_work,
	output logic             in_pop,
	output logic             valid,
	input  wire logic        stall,
	output logic [31:0]      single_bits,
	output logic             last_out
);
	import te2f_pkg::*;

	// stage 1: leading-zero count and normalize
	logic        v_s1, direct_s1, sign_s1, last_s1, zero_s1;
	logic [31:0] bits_s1;
	logic [63:0] norm_s1;
	logic [12:0] be_s1;
	logic        adv1, adv2;

	logic [5:0]  lz;
	logic [63:0] nrm;

	assign adv2 = !valid || !stall;
	assign adv1 = !v_s1 || adv2;
	assign in_pop = in_valid && adv1;

	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (in_work.mag[i]) lz = 6'(63 - i);
		end
		nrm = in_work.mag << lz;
	end

	// stage 2 rounding
	logic [7:0]  sh;
	logic        under;
	logic [127:0] wide;
	logic [63:0] sig, rem, half;
	logic [24:0] sigr;
	logic [32:0] packed_v;
	logic [31:0] res;

	always_comb begin
		sh = 8'd40;
		under = 1'b0;
		if ($signed(be_s1) < 13'sd1) begin
			if ($signed(be_s1) < -13'sd23) under = 1'b1;
			else sh = 8'(13'd41 - be_s1);
		end
		wide = {norm_s1, 64'd0} >> sh;
		sig  = wide[127:64];
		rem  = wide[63:0];
		half = 64'h8000_0000_0000_0000;
		sigr = 25'(sig) + 25'(((rem > half) || (rem == half && sig[0])) ? 1 : 0);
		packed_v = ($signed(be_s1) >= 13'sd1) ? (33'({be_s1[7:0] - 8'd1, 23'd0}) + 33'(sigr))
			: 33'(sigr);
		if (direct_s1) res = bits_s1;
		else if (zero_s1 || under) res = {sign_s1, 31'd0};
		else if ($signed(be_s1) >= 13'sd255 || packed_v >= 33'(POS_INF))
			res = {sign_s1, 31'd0} | POS_INF;
		else res = {sign_s1, packed_v[30:0]};
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			direct_s1 <= in_work.direct;
			bits_s1 <= in_work.bits;
			sign_s1 <= in_work.sign;
			last_s1 <= in_work.last;
			zero_s1 <= in_work.mag == '0;
			norm_s1 <= nrm;
			be_s1 <= 13'({in_work.exp2[11], in_work.exp2}) + 13'd190 - 13'({7'd0, lz});
		end
		if (adv2) begin
			single_bits <= res;
			last_out <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			valid <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) valid <= v_s1;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/te2f_checker.sv
// Port-level checks for tensor_element_to_fp32, bound to the top level.
// No package dependency.
`default_nettype none
module te2f_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [31:0] single_bits,
	input wire logic cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(single_bits)) else $error("out hold");
	// a full queue drains one entry in any cycle the receiver takes a transfer
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall) else $error("stall not released");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 !out_valid |-> !in_stall) else $error("stall while empty");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready) else $error("cfg");
endmodule

bind tensor_element_to_fp32 te2f_checker u_chk (.clk, .arst_n, .in_stall,
	.out_valid, .out_stall, .single_bits, .cfg_ready);
`default_nettype wire

FILE: test/tensor_element_to_fp32_test.sv
// Self-checking testbench for tensor_element_to_fp32: random and directed
// elements of each defined type and codes 12, 14, 15, checked against a
// built-in binary32 predictor. Depends on te2f_pkg and tensor_element_to_fp32.
`default_nettype none
module tensor_element_to_fp32_test;
	import te2f_pkg::*;

	class fp32_scoreboard;
		logic [32:0] pending_words[$];   // {last, single bits}
		int mismatches;

		function automatic logic [31:0] round_to_single(logic [31:0] sgn, logic [63:0] mag,
				int exp2);
			int e;
			int be;
			int sh;
			logic [63:0] sig;
			logic [63:0] rem;
			logic [63:0] half;
			logic [63:0] word;
			if (mag == 64'd0) return sgn;
			e = exp2 + 63;
			while (!mag[63]) begin
				mag = mag << 1;
				e--;
			end
			be = e + 127;
			if (be >= 255) return sgn | POS_INF;
			sh = (be >= 1) ? 40 : 40 + (1 - be);
			if (sh > 64) return sgn;
			if (sh == 64) begin
				sig = 64'd0;
				rem = mag;
				half = 64'd1 << 63;
			end else begin
				sig = mag >> sh;
				rem = mag & ((64'd1 << sh) - 64'd1);
				half = 64'd1 << (sh - 1);
			end
			if (rem > half || (rem == half && sig[0])) sig++;
			word = (be >= 1) ? ((64'(be - 1) << 23) + sig) : sig;
			if (word >= 64'h7F80_0000) return sgn | POS_INF;
			return sgn | word[31:0];
		endfunction

		function automatic logic [31:0] widen_half(logic [15:0] h);
			logic [31:0] sgn;
			logic [4:0] ex;
			logic [9:0] man;
			sgn = {h[15], 31'd0};
			ex = h[14:10];
			man = h[9:0];
			if (ex == 5'd0) return round_to_single(sgn, 64'(man), -24);
			if (ex == 5'h1F) return sgn | POS_INF | (32'(man) << 13);
			return sgn | ((32'(ex) + 32'd112) << 23) | (32'(man) << 13);
		endfunction

		function automatic logic [31:0] widen_e4m3(logic [7:0] b);
			logic [31:0] sgn;
			logic [3:0] ex;
			logic [2:0] man;
			sgn = {b[7], 31'd0};
			ex = b[6:3];
			man = b[2:0];
			if (ex == 4'd0) return round_to_single(sgn, 64'(man), -9);
			if (ex == 4'd15 && man == 3'd7) return sgn | QNAN;
			return sgn | ((32'(ex) + 32'd120) << 23) | (32'(man) << 20);
		endfunction

		function automatic logic [31:0] narrow_double(logic [63:0] d);
			logic [31:0] sgn;
			logic [10:0] ex;
			logic [63:0] man;
			sgn = {d[63], 31'd0};
			ex = d[62:52];
			man = {12'd0, d[51:0]};
			if (ex == 11'h7FF) begin
				if (man == 64'd0) return sgn | POS_INF;
				return sgn | QNAN | 32'(man >> 29);
			end
			if (ex == 11'd0) return round_to_single(sgn, man, -1074);
			return round_to_single(sgn, man | (64'd1 << 52), int'(ex) - 1075);
		endfunction

		function automatic logic [31:0] from_twos(logic [63:0] v, int width);
			logic [63:0] mask;
			logic [63:0] x;
			mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
			x = v & mask;
			if (x[width-1]) return round_to_single(32'h8000_0000, ((~x) + 64'd1) & mask, 0);
			return round_to_single(32'd0, x, 0);
		endfunction

		function automatic logic [31:0] convert(logic [3:0] etype, logic [63:0] x);
			case (etype)
				TYPE_F64:  return narrow_double(x);
				TYPE_F32:  return x[31:0];
				TYPE_F16:  return widen_half(x[15:0]);
				TYPE_BF16: return {x[15:0], 16'd0};
				TYPE_E5M2: return widen_half({x[7:0], 8'd0});
				TYPE_E4M3: return widen_e4m3(x[7:0]);
				TYPE_I64:  return from_twos(x, 64);
				TYPE_I32:  return from_twos(x, 32);
				TYPE_I16:  return from_twos(x, 16);
				TYPE_I8:   return from_twos(x, 8);
				TYPE_U8:   return round_to_single(32'd0, {56'd0, x[7:0]}, 0);
				TYPE_BOOL: return (x[7:0] != 8'd0) ? 32'h3F80_0000 : 32'd0;
				default:   return 32'd0;
			endcase
		endfunction

		function void note_element(logic [3:0] etype, logic [63:0] x, logic last);
			pending_words.push_back({last, convert(etype, x)});
		endfunction

		function void check_word(logic [31:0] word, logic last);
			logic [32:0] want;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h last %b", word, last);
				return;
			end
			want = pending_words.pop_front();
			if (want != {last, word}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h last %b, got %h last %b",
						want[31:0], want[32], word, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] element_bits = 64'd0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] single_bits;
	logic last_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_data = 4'd0;

	fp32_scoreboard board = new();
	logic [3:0] cur_type = TYPE_F32;
	bit quiet = 0;
	bit long_hold = 0;

	tensor_element_to_fp32 uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.element_bits(element_bits), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.single_bits(single_bits), .last_out(last_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 400000);
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(single_bits, last_out);
	end

	// Receiver: random stall bursts, one long hold on request, none when quiet.
	initial begin
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 0;
				@(posedge clk);
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	task automatic send_element(logic [63:0] x, logic last);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_bits <= x;
		last_in <= last;
		do @(posedge clk); while (in_stall);
		board.note_element(cur_type, x, last);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_type(logic [3:0] t);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= t;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_type = t;
	endtask

	function automatic logic [63:0] random_element(logic [3:0] t);
		logic [63:0] x;
		logic [10:0] ex;
		x = {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
			0: ;
			1: x[62:0] = 63'($urandom_range(0, 300));
			2: begin
				// double exponents around the binary32 range edges
				case ($urandom_range(0, 3))
					0: ex = 11'($urandom_range(840, 920));
					1: ex = 11'($urandom_range(1140, 1160));
					2: ex = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
					default: ex = 11'($urandom_range(0, 2047));
				endcase
				if (t == TYPE_F64) x[62:52] = ex;
				else if (t == TYPE_I64 || t == TYPE_I32) x[28:0] = 29'(1 << 28);
			end
			default: begin
				if ($urandom_range(0, 1)) x[31:0] = 32'hFFFF_FFFF;
				if ($urandom_range(0, 1)) x[7:0] = 8'h00;
			end
		endcase
		return x;
	endfunction

	initial begin
		int i;
		int p;
		logic [3:0] order[16] = '{TYPE_F32, TYPE_F64, TYPE_F16, TYPE_BF16, TYPE_E5M2,
			TYPE_E4M3, TYPE_I64, TYPE_I32, TYPE_I16, TYPE_I8, TYPE_U8, TYPE_BOOL,
			4'd12, 4'd15, TYPE_F64, TYPE_I64};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset type is f32
		send_element(64'hDEAD_BEEF_3F80_0000, 1'b0);
		write_type(TYPE_F64);
		send_element(64'h7FF8_0000_0000_0001, 1'b0);   // NaN
		send_element(64'hFFF0_0000_0000_0000, 1'b0);   // -inf
		send_element(64'h47EF_FFFF_F000_0000, 1'b0);   // rounds up to infinity
		send_element(64'h36A0_0000_0000_0000, 1'b0);   // smallest subnormal
		send_element(64'h3690_0000_0000_0000, 1'b1);   // tie to zero
		send_element(64'h8000_0000_0000_0000, 1'b0);
		write_type(TYPE_F16);
		send_element(64'hFFFF_FFFF_FFFF_0001, 1'b0);
		send_element(64'h0000_0000_0000_FC01, 1'b1);
		write_type(TYPE_E4M3);
		send_element(64'h0000_0000_0000_00FF, 1'b0);
		send_element(64'h0000_0000_0000_007F, 1'b0);
		send_element(64'h0000_0000_0000_0080, 1'b0);
		send_element(64'h0000_0000_0000_0001, 1'b1);
		write_type(TYPE_I64);
		send_element(64'h8000_0000_0000_0000, 1'b0);
		send_element(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_element(64'h0000_0000_0000_0000, 1'b1);
		write_type(TYPE_I32);
		send_element(64'hFFFF_FFFF_7FFF_FFFF, 1'b0);
		send_element(64'h0000_0000_0100_0003, 1'b0);
		write_type(TYPE_BOOL);
		send_element(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
		send_element(64'h0000_0000_0000_0080, 1'b1);
		write_type(4'd14);
		send_element(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

		for (p = 0; p < 16; p++) begin
			write_type(order[p]);
			if (p == 3) long_hold = 1;
			if (p == 15) quiet = 1;
			for (i = 0; i < 38; i++)
				send_element(random_element(cur_type), 1'($urandom_range(0, 1)));
		end

		drain();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
hdl/te2f_pkg.sv
hdl/te2f_front.sv
hdl/te2f_queue.sv
hdl/te2f_back.sv
hdl/tensor_element_to_fp32.sv
hdl/te2f_checker.sv
test/tensor_element_to_fp32_test.sv
